>>> rtl/double_ended_queue_top_defines.svh
// Assertion macros for the deque RTL, used by deq_core.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition in one cycle implies a property in the next.
`define DEQ_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error(msg);

`endif

>>> rtl/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_PUSH_RIGHT = 2'd0,
    OP_POP_LEFT   = 2'd1,
    OP_POP_RIGHT  = 2'd2,
    OP_PEEK       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] item;
  } request_t;

  typedef struct packed {
    logic [31:0] popped_item;
    logic [31:0] left_item;
    logic [31:0] right_item;
    logic [10:0] occupancy;
    logic        is_empty;
    logic        is_full;
    err_t        error_code;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/deq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_ram import deq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int PW        = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [PW-1:0]         waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [PW-1:0]         raddr,
  output logic      [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/deq_outq.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result buffer: output register plus one skid entry.
module deq_outq import deq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         rsp_valid,
  input  wire logic    rsp_stall,
  output result_t      rsp
);

  logic    skid_valid;
  result_t skid;
  logic    take;

  assign take = rsp_valid && !rsp_stall;
  assign full = rsp_valid && skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!rsp_valid || take) begin
        if (skid_valid) begin
          rsp_valid  <= 1'b1;
          skid_valid <= push;
        end else begin
          rsp_valid  <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || take) begin
      if (skid_valid) begin
        rsp <= skid;
        if (push) begin
          skid <= push_data;
        end
      end else if (push) begin
        rsp <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/deq_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_top_defines.svh"

// Pointer, count and end-value control. The end items are cached in
// registers; a pop fetches the new end from the memory.
module deq_core import deq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int PW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire request_t              req,
  output logic                       res_valid,
  output result_t                    res,
  input  wire logic                  outq_full,
  output logic                       we,
  output logic      [PW-1:0]         waddr,
  output logic      [DATA_WIDTH-1:0] wdata,
  output logic                       re,
  output logic      [PW-1:0]         raddr,
  input  wire logic [DATA_WIDTH-1:0] rdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t                st, st_next;
  logic [PW-1:0]         lp, lp_next;
  logic [PW-1:0]         rp, rp_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [DATA_WIDTH-1:0] left_val, left_next;
  logic [DATA_WIDTH-1:0] right_val, right_next;
  logic [DATA_WIDTH-1:0] popped, popped_next;
  logic                  sel_left, sel_left_next;

  logic                  accept;
  logic [DATA_WIDTH-1:0] value;
  logic                  empty, full;
  logic [PW-1:0]         lp_inc, lp_dec, rp_inc, rp_dec;
  logic [DATA_WIDTH-1:0] pop_out;
  err_t                  err;

  assign req_stall = (st != ST_IDLE) || outq_full;
  assign accept    = req_valid && !req_stall;
  assign value     = DATA_WIDTH'(64'(req.item));
  assign empty     = (cnt == '0);
  assign full      = (cnt == CW'(DEPTH));

  // rp always sits one behind lp + cnt, so an empty queue has rp = lp - 1
  assign lp_inc = (lp == PW'(DEPTH - 1)) ? '0 : lp + 1'b1;
  assign lp_dec = (lp == '0) ? PW'(DEPTH - 1) : lp - 1'b1;
  assign rp_inc = (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
  assign rp_dec = (rp == '0) ? PW'(DEPTH - 1) : rp - 1'b1;

  always_comb begin
    st_next       = st;
    lp_next       = lp;
    rp_next       = rp;
    cnt_next      = cnt;
    left_next     = left_val;
    right_next    = right_val;
    popped_next   = popped;
    sel_left_next = sel_left;
    we            = 1'b0;
    waddr         = rp_inc;
    wdata         = value;
    re            = 1'b0;
    raddr         = lp_inc;
    res_valid     = 1'b0;
    pop_out       = '0;
    err           = ERR_OK;

    unique case (st)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            OP_PUSH_RIGHT: begin
              res_valid = 1'b1;
              if (full) begin
                err = ERR_FULL;
              end else begin
                we         = 1'b1;
                rp_next    = rp_inc;
                cnt_next   = cnt + CW'(1);
                right_next = value;
                if (empty) begin
                  left_next = value;
                end
              end
            end
            OP_POP_LEFT: begin
              if (empty) begin
                res_valid = 1'b1;
                err       = ERR_EMPTY;
              end else begin
                re            = 1'b1;
                raddr         = lp_inc;
                lp_next       = lp_inc;
                cnt_next      = cnt - CW'(1);
                popped_next   = left_val;
                sel_left_next = 1'b1;
                st_next       = ST_READ;
              end
            end
            OP_POP_RIGHT: begin
              if (empty) begin
                res_valid = 1'b1;
                err       = ERR_EMPTY;
              end else begin
                re            = 1'b1;
                raddr         = rp_dec;
                rp_next       = rp_dec;
                cnt_next      = cnt - CW'(1);
                popped_next   = right_val;
                sel_left_next = 1'b0;
                st_next       = ST_READ;
              end
            end
            OP_PEEK: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        // new end item arrives from the memory this cycle
        res_valid = 1'b1;
        pop_out   = popped;
        if (sel_left) begin
          left_next = rdata;
        end else begin
          right_next = rdata;
        end
        st_next = ST_IDLE;
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase

    res.popped_item = 32'(64'(pop_out));
    res.left_item   = (cnt_next == '0) ? '0 : 32'(64'(left_next));
    res.right_item  = (cnt_next == '0) ? '0 : 32'(64'(right_next));
    res.occupancy   = 11'(cnt_next);
    res.is_empty    = (cnt_next == '0);
    res.is_full     = (cnt_next == CW'(DEPTH));
    res.error_code  = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_IDLE;
      lp  <= '0;
      rp  <= PW'(DEPTH - 1);
      cnt <= '0;
    end else begin
      st  <= st_next;
      lp  <= lp_next;
      rp  <= rp_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    left_val  <= left_next;
    right_val <= right_next;
    popped    <= popped_next;
    sel_left  <= sel_left_next;
  end

  `DEQ_ASSERT(a_cnt_range, cnt <= CW'(DEPTH), "item count above depth")
  `DEQ_ASSERT(a_no_overflow, res_valid |-> !outq_full, "result issued into full buffer")
  `DEQ_ASSERT(a_empty_ptrs, (cnt == '0) |-> (rp == lp_dec), "end pointers disagree when empty")
  `DEQ_ASSERT_NEXT(a_peek_hold, accept && req.operation == OP_PEEK, $stable(cnt) && $stable(lp),
                   "peek changed queue state")

endmodule

`default_nettype wire

>>> rtl/double_ended_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue over a circular memory of DEPTH entries of DATA_WIDTH bits.
// Each req transaction is one operation (push right, pop left, pop right, peek) and
// produces exactly one rsp transaction with the popped item, both end items, the
// count, flags and an error code; a failed push or pop leaves the queue untouched.
// Push, peek and failed operations yield a result in the cycle they are taken; a
// successful pop yields it from ST_READ, as the new end item comes via the single
// read port of the memory, whose output is registered. The end items are held in
// registers, so no other operation reads the memory. A two-entry result buffer lets
// a new request be taken while one result waits on rsp_stall. There is no clearing
// pass after reset; an unwritten entry read when the last item pops is never shown.
module double_ended_queue_top import deq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire request_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output result_t       rsp
);

  localparam int PW = $clog2(DEPTH);

  logic                  res_valid;
  result_t               res;
  logic                  outq_full;
  logic                  we, re;
  logic [PW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  deq_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .outq_full (outq_full),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  deq_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (outq_full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
